>>> rtl/core/sbeu_pkg.sv
// shared types, opcodes and status codes for the stack bytecode execute unit
package sbeu_pkg;

    localparam int STACK_ENTRIES = 16;
    localparam int SLOT_ENTRIES  = 16;
    localparam int SP_W   = $clog2(STACK_ENTRIES);
    localparam int DEPTH_W = $clog2(STACK_ENTRIES + 1);
    localparam int SLOT_W = $clog2(SLOT_ENTRIES);

    localparam logic [7:0] OP_END   = 8'h00;
    localparam logic [7:0] OP_PUSH  = 8'h01;
    localparam logic [7:0] OP_LOAD  = 8'h02;
    localparam logic [7:0] OP_STORE = 8'h03;
    localparam logic [7:0] OP_ADD   = 8'h04;
    localparam logic [7:0] OP_SUB   = 8'h05;
    localparam logic [7:0] OP_MUL   = 8'h06;
    localparam logic [7:0] OP_DIV   = 8'h07;
    localparam logic [7:0] OP_MOD   = 8'h08;
    localparam logic [7:0] OP_EQ    = 8'h09;
    localparam logic [7:0] OP_LT    = 8'h0a;
    localparam logic [7:0] OP_GT    = 8'h0b;
    localparam logic [7:0] OP_NOT   = 8'h0c;
    localparam logic [7:0] OP_DUP   = 8'h0d;
    localparam logic [7:0] OP_DROP  = 8'h0e;
    localparam logic [7:0] OP_JMP   = 8'h10;
    localparam logic [7:0] OP_JZ    = 8'h11;
    localparam logic [7:0] OP_JNZ   = 8'h12;
    localparam logic [7:0] OP_EVLD  = 8'h13;

    localparam logic [1:0] CFG_SLOT_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_CODE_LENGTH = 2'd1;
    localparam logic [1:0] CFG_STEP_BUDGET = 2'd2;

    typedef enum logic [3:0] {
        ST_OK     = 4'd0,
        ST_END    = 4'd1,
        ST_BADOP  = 4'd2,
        ST_OVER   = 4'd3,
        ST_UNDER  = 4'd4,
        ST_SLOT   = 4'd5,
        ST_JUMP   = 4'd6,
        ST_DIVZ   = 4'd7,
        ST_BUDGET = 4'd8,
        ST_EVLOAD = 4'd9,
        ST_HOST   = 4'd10
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_DIV,
        S_DONE,
        S_OUT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic read;
        logic exec;
        logic div_start;
        logic div_step;
        logic commit;
    } ctrl_t;

    // status from datapath to controller
    typedef struct packed {
        logic need_div;
        logic div_last;
    } stat_t;

    function automatic logic is_host_op(input logic [7:0] op);
        return (op >= 8'h20 && op <= 8'h26) || (op >= 8'h30 && op <= 8'h36) ||
               (op >= 8'h40 && op <= 8'h46) || (op >= 8'h50 && op <= 8'h55) ||
               (op >= 8'h58 && op <= 8'h60);
    endfunction

endpackage

>>> rtl/core/sbeu_ctrl.sv
// controller state machine sequencing one item through the datapath
module sbeu_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  sbeu_pkg::stat_t stat,
    output sbeu_pkg::ctrl_t ctrl
);
    import sbeu_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_tvalid) state_next = S_READ;
            S_READ: state_next = S_EXEC;
            S_EXEC: state_next = stat.need_div ? S_DIV : S_DONE;
            S_DIV:  if (stat.div_last) state_next = S_DONE;
            S_DONE: state_next = S_OUT;
            S_OUT:  if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = aresetn;
                ctrl.capture = s_tvalid;
            end
            S_READ: ctrl.read = 1'b1;
            S_EXEC: begin
                ctrl.exec = 1'b1;
                ctrl.div_start = stat.need_div;
            end
            S_DIV:  ctrl.div_step = 1'b1;
            S_DONE: ctrl.commit = 1'b1;
            S_OUT:  m_tvalid = 1'b1;
            default: ;
        endcase
    end

    a_out_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) |=> m_tvalid)
        else $error("result not presented after commit");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input accepted while result pending");
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped before transfer");

endmodule

>>> rtl/core/sbeu_datapath.sv
// operand stack, slots, event words, alu, iterative divider and result register
module sbeu_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [216:0]      s_tdata,
    input  logic              cfg_valid,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  sbeu_pkg::ctrl_t   ctrl,
    output sbeu_pkg::stat_t   stat,
    output logic [63:0]       m_tdata
);
    import sbeu_pkg::*;

    logic [4:0]  slot_limit_reg;
    logic [15:0] code_length_reg, step_budget_reg;

    logic [216:0] item_reg;
    logic [31:0] stack_mem [STACK_ENTRIES];
    logic [31:0] slot_reg [SLOT_ENTRIES];
    logic [31:0] ev_reg [4];
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [15:0] steps_reg;

    logic [31:0] a_reg, b_reg, sl_reg, res_reg, res_next;
    logic [3:0]  st_reg, st_next;
    logic [15:0] nxt_reg, nxt_next;
    logic        wr_en_reg, wr_en_next, sl_en_reg, sl_en_next;
    logic [SP_W-1:0] wr_idx_reg, wr_idx_next;
    logic [SLOT_W-1:0] sl_idx_reg, sl_idx_next;
    logic [31:0] sl_val_reg, sl_val_next;

    // divider
    logic [31:0] q_reg, r_reg, dv_reg;
    logic [5:0]  cnt_reg;
    logic        neg_q_reg, neg_r_reg, is_mod_reg;

    logic [63:0] out_reg;

    wire        req  = item_reg[0];
    wire [7:0]  op   = item_reg[136:129];
    wire [31:0] lit  = item_reg[168:137];
    wire [15:0] offs = item_reg[184:169];
    wire [7:0]  b1   = item_reg[192:185];
    wire [7:0]  b2   = item_reg[200:193];
    wire [15:0] aft  = item_reg[216:201];

    wire [SP_W-1:0] top_i  = SP_W'(depth_reg - 1'b1);
    wire [SP_W-1:0] sec_i  = SP_W'(depth_reg - 2'd2);
    wire [SP_W-1:0] push_i = SP_W'(depth_reg);

    // top after the step, taking the write of this step into account
    wire [31:0] top_val = (wr_en_reg && wr_idx_reg == top_i) ? res_reg : stack_mem[top_i];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_limit_reg  <= 5'd16;
            code_length_reg <= '0;
            step_budget_reg <= 16'd4096;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SLOT_LIMIT:  slot_limit_reg  <= cfg_data[4:0];
                CFG_CODE_LENGTH: code_length_reg <= cfg_data;
                CFG_STEP_BUDGET: step_budget_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.capture) item_reg <= s_tdata;
        if (ctrl.read) begin
            a_reg  <= stack_mem[sec_i];
            b_reg  <= stack_mem[top_i];
            sl_reg <= slot_reg[SLOT_W'(b1)];
        end
        if (ctrl.commit && wr_en_reg) stack_mem[wr_idx_reg] <= res_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
            steps_reg <= '0;
            for (int i = 0; i < SLOT_ENTRIES; i++) slot_reg[i] <= '0;
            for (int i = 0; i < 4; i++) ev_reg[i] <= '0;
        end else if (ctrl.exec) begin
            depth_reg <= depth_next;
            if (!req) begin
                ev_reg[0] <= item_reg[32:1];
                ev_reg[1] <= item_reg[64:33];
                ev_reg[2] <= item_reg[96:65];
                ev_reg[3] <= item_reg[128:97];
                steps_reg <= '0;
            end else if (steps_reg < step_budget_reg) begin
                steps_reg <= steps_reg + 16'd1;
            end
        end else if (ctrl.commit && sl_en_reg) begin
            slot_reg[sl_idx_reg] <= sl_val_reg;
        end
    end

    wire slot1_ok = ({3'b0, slot_limit_reg} > b1) && (b1 < SLOT_ENTRIES);
    wire slot2_ok = ({3'b0, slot_limit_reg} > b2) && (b2 < SLOT_ENTRIES);
    wire empty    = depth_reg == '0;
    wire full     = depth_reg >= DEPTH_W'(STACK_ENTRIES);
    wire two      = depth_reg >= DEPTH_W'(2);
    wire is_div   = (op == OP_DIV) || (op == OP_MOD);
    wire div_go   = req && (steps_reg < step_budget_reg) && is_div && two && (b_reg != '0);
    wire [16:0] tgt = {1'b0, aft} + {offs[15], offs};
    wire [31:0] mul_lo = a_reg * b_reg;

    assign stat.need_div = div_go;
    assign stat.div_last = cnt_reg == 6'd1;

    always_comb begin
        logic take;
        take = 1'b0;
        st_next = ST_OK; nxt_next = aft; res_next = '0;
        wr_en_next = 1'b0; wr_idx_next = push_i;
        sl_en_next = 1'b0; sl_idx_next = SLOT_W'(b1); sl_val_next = b_reg;
        depth_next = depth_reg;
        if (!req) begin
            depth_next = '0;
        end else if (steps_reg >= step_budget_reg) begin
            st_next = ST_BUDGET;
        end else begin
            case (op)
                OP_END: st_next = ST_END;
                OP_PUSH, OP_LOAD: begin
                    if (op == OP_LOAD && !slot1_ok) st_next = ST_SLOT;
                    else if (full) st_next = ST_OVER;
                    else begin
                        wr_en_next = 1'b1;
                        res_next = (op == OP_PUSH) ? lit : sl_reg;
                        depth_next = depth_reg + 1'b1;
                    end
                end
                OP_STORE: begin
                    if (!slot1_ok) st_next = ST_SLOT;
                    else if (empty) st_next = ST_UNDER;
                    else begin
                        sl_en_next = 1'b1;
                        depth_next = depth_reg - 1'b1;
                    end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EQ, OP_LT, OP_GT: begin
                    if (!two) st_next = ST_UNDER;
                    else if (is_div && b_reg == '0) st_next = ST_DIVZ;
                    else begin
                        wr_en_next = 1'b1;
                        wr_idx_next = sec_i;
                        depth_next = depth_reg - 1'b1;
                        case (op)
                            OP_ADD: res_next = a_reg + b_reg;
                            OP_SUB: res_next = a_reg - b_reg;
                            OP_MUL: res_next = mul_lo;
                            OP_EQ:  res_next = {31'b0, a_reg == b_reg};
                            OP_LT:  res_next = {31'b0, $signed(a_reg) < $signed(b_reg)};
                            OP_GT:  res_next = {31'b0, $signed(a_reg) > $signed(b_reg)};
                            default: res_next = '0;
                        endcase
                    end
                end
                OP_NOT: begin
                    if (empty) st_next = ST_UNDER;
                    else begin
                        wr_en_next = 1'b1; wr_idx_next = top_i;
                        res_next = {31'b0, b_reg == '0};
                    end
                end
                OP_DUP: begin
                    if (empty) st_next = ST_UNDER;
                    else if (full) st_next = ST_OVER;
                    else begin
                        wr_en_next = 1'b1; res_next = b_reg;
                        depth_next = depth_reg + 1'b1;
                    end
                end
                OP_DROP: begin
                    if (empty) st_next = ST_UNDER;
                    else depth_next = depth_reg - 1'b1;
                end
                OP_JMP, OP_JZ, OP_JNZ: begin
                    take = (op == OP_JMP) || ((op == OP_JZ) == (b_reg == '0));
                    if (op != OP_JMP && empty) st_next = ST_UNDER;
                    else if (take && (tgt[16] || tgt[15:0] >= code_length_reg))
                        st_next = ST_JUMP;
                    else begin
                        if (take) nxt_next = tgt[15:0];
                        if (op != OP_JMP) depth_next = depth_reg - 1'b1;
                    end
                end
                OP_EVLD: begin
                    if (b1 >= 8'd4 || !slot2_ok) st_next = ST_EVLOAD;
                    else begin
                        sl_en_next = 1'b1;
                        sl_idx_next = SLOT_W'(b2);
                        sl_val_next = ev_reg[b1[1:0]];
                    end
                end
                default: st_next = is_host_op(op) ? ST_HOST : ST_BADOP;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.exec) begin
            st_reg <= st_next; nxt_reg <= nxt_next; res_reg <= res_next;
            wr_en_reg <= wr_en_next; wr_idx_reg <= wr_idx_next;
            sl_en_reg <= sl_en_next; sl_idx_reg <= sl_idx_next; sl_val_reg <= sl_val_next;
        end
        if (ctrl.div_start) begin
            q_reg <= a_reg[31] ? -a_reg : a_reg;
            dv_reg <= b_reg[31] ? -b_reg : b_reg;
            r_reg <= '0;
            cnt_reg <= 6'd32;
            neg_q_reg <= a_reg[31] ^ b_reg[31];
            neg_r_reg <= a_reg[31];
            is_mod_reg <= op == OP_MOD;
        end else if (ctrl.div_step) begin
            // restoring division, one quotient bit a cycle
            logic [32:0] trial;
            trial = {r_reg, q_reg[31]} - {1'b0, dv_reg};
            if (!trial[32]) r_reg <= trial[31:0];
            else r_reg <= {r_reg[30:0], q_reg[31]};
            q_reg <= {q_reg[30:0], !trial[32]};
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                if (is_mod_reg)
                    res_reg <= neg_r_reg ? -(trial[32] ? {r_reg[30:0], q_reg[31]}
                               : trial[31:0]) : (trial[32] ? {r_reg[30:0], q_reg[31]}
                               : trial[31:0]);
                else
                    res_reg <= neg_q_reg ? -{q_reg[30:0], !trial[32]}
                               : {q_reg[30:0], !trial[32]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.commit)
            out_reg <= {7'b0, depth_reg, empty ? 32'b0 : top_val, nxt_reg, st_reg};
    end

    assign m_tdata = {out_reg[63:57], out_reg[56:0]};

    a_depth_range: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DEPTH_W'(STACK_ENTRIES))
        else $error("depth beyond stack size");
    a_begin_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.exec && !req) |=> (depth_reg == '0 && steps_reg == '0))
        else $error("begin did not clear state");
    a_budget_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.exec && req && steps_reg >= step_budget_reg) |=> $stable(depth_reg))
        else $error("state changed with budget spent");

endmodule

>>> rtl/core/stack_bytecode_execute_unit.sv
// top level of the stack bytecode execute unit
// One item is handled at a time. After the input transfer the item passes through stack read,
// execute, commit and present before the result is offered, and the next item is taken in the
// cycle after the result transfer; div and mod add the steps of the bit-serial divider, and
// output back-pressure can hold the result further.
// The result register holds the result until it is transferred. Begin items clear depth
// and step count; configuration writes are taken at any time out of reset and meant for
// idle periods.
module stack_bytecode_execute_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // req_type
    input  logic         s_tuser,
    // event_kind, event_ident, event_handle_word, event_payload, op_code,
    // push_literal, jump_offset, first_byte, second_byte, after_address
    input  logic [215:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, next_address, top_value, stack_depth
    output logic [63:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import sbeu_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    assign cfg_ready = aresetn;

    sbeu_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .stat(stat), .ctrl(ctrl)
    );

    sbeu_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .s_tdata({s_tdata, s_tuser}),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .ctrl(ctrl), .stat(stat), .m_tdata(m_tdata)
    );

endmodule
